>>> sv/lc3_pkg.sv
// Shared types, codes and helpers for the LC-3 instruction-step core.
// No dependencies; used by lc3_instruction_step.
`default_nettype none
package lc3_pkg;

   localparam int MEM_WORDS_DEFAULT = 65536;
   localparam logic [15:0] START_PC_RESET = 16'h3000;
   localparam logic [15:0] KB_STATUS_ADDR = 16'hFE00;
   localparam logic [15:0] KB_DATA_ADDR   = 16'hFE02;

   localparam logic [2:0] FLAG_N = 3'b100;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_P = 3'b001;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CHAR    = 3'd1;
   localparam logic [2:0] ST_STRING  = 3'd2;
   localparam logic [2:0] ST_PSTRING = 3'd3;
   localparam logic [2:0] ST_NEEDKEY = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;
   localparam logic [2:0] ST_ILLEGAL = 3'd6;

   localparam logic [3:0] OP_BR  = 4'd0;
   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_LD  = 4'd2;
   localparam logic [3:0] OP_ST  = 4'd3;
   localparam logic [3:0] OP_JSR = 4'd4;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_LDR = 4'd6;
   localparam logic [3:0] OP_STR = 4'd7;
   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_NOT = 4'd9;
   localparam logic [3:0] OP_LDI = 4'd10;
   localparam logic [3:0] OP_STI = 4'd11;
   localparam logic [3:0] OP_JMP = 4'd12;
   localparam logic [3:0] OP_RES = 4'd13;
   localparam logic [3:0] OP_LEA = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [7:0] TV_GETC  = 8'h20;
   localparam logic [7:0] TV_OUT   = 8'h21;
   localparam logic [7:0] TV_PUTS  = 8'h22;
   localparam logic [7:0] TV_IN    = 8'h23;
   localparam logic [7:0] TV_PUTSP = 8'h24;
   localparam logic [7:0] TV_HALT  = 8'h25;

   localparam logic KIND_LOAD = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [15:0] load_address;
      logic [15:0] load_data;
      logic        key_ready;
      logic [7:0]  key_char;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] next_pc;
      logic [7:0]  out_char;
      logic [15:0] string_address;
      logic        key_taken;
   } rsp_type;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) f = FLAG_Z;
      else if (v[15]) f = FLAG_N;
      else f = FLAG_P;
      return f;
   endfunction

endpackage
`default_nettype wire

>>> sv/lc3_instruction_step.sv
// LC-3 instruction-step core: one synchronous word memory, register file, sequencer.
// Depends on lc3_pkg.
//
// Usage: the req channel (req_valid/req_stall, req_data) carries load words
// (kind 0, write one memory word) and step words (kind 1, run one
// instruction). Each accepted word gives exactly one rsp word
// (rsp_valid/rsp_stall, rsp_data). csr_valid/csr_ready writes start_pc and
// reloads the program counter; csr_ready is always high.
// After reset the memory is cleared one word a cycle while req_stall stays
// high; configuration writes are taken meanwhile.
// A load word, or a step word while stopped, goes straight to the finish state;
// a step word fetches through the memory read and executes, LD/LDR add a data
// read, LDI and STI a pointer read, and a keyboard status read skips the wait
// state (S_KBD writes the key data when a key is ready). One word is in flight at a time.
// A finished word sits in the rsp register; the next req word is taken
// while it waits, and the core holds its result internally until the rsp
// register frees when the receiver stalls.
// Memory addresses wrap by the low log2(MEMORY_WORDS) bits (power of two).
`default_nettype none
module lc3_instruction_step #(
   parameter int MEMORY_WORDS = lc3_pkg::MEM_WORDS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lc3_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lc3_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [15:0]      csr_data
);
   import lc3_pkg::*;

   localparam int AW = $clog2(MEMORY_WORDS);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_KBD  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_PH   = 3'd5;
   localparam logic [2:0] S_EXEC = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   localparam logic [1:0] PH_FETCH = 2'd0;
   localparam logic [1:0] PH_IND   = 2'd1;
   localparam logic [1:0] PH_LOAD  = 2'd2;
   localparam logic [1:0] PH_STORE = 2'd3;

   logic [15:0] mem [MEMORY_WORDS];
   logic [15:0] mem_q;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;

   logic [15:0] regs_ff [8];
   logic        reg_we, r7_we;
   logic [2:0]  reg_wa;
   logic [15:0] reg_wd;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] dat_ff, dat_in;
   logic [15:0] ir_ff, ir_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] start_pc_ff, start_pc_in;
   logic [2:0]  flags_ff, flags_in;
   logic        stopped_ff, stopped_in;
   logic        taken_ff, taken_in;
   logic        key_ready_ff, key_ready_in;
   logic [7:0]  key_char_ff, key_char_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  ochar_ff, ochar_in;
   logic [15:0] saddr_ff, saddr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [3:0]  opc;
   logic [2:0]  dr, sr1;
   logic [15:0] off9, off6, off11, opb, kb_val;
   logic [7:0]  vec;

   assign opc   = ir_ff[15:12];
   assign dr    = ir_ff[11:9];
   assign sr1   = ir_ff[8:6];
   assign vec   = ir_ff[7:0];
   assign off9  = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6  = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign off11 = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign opb   = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
   assign kb_val = key_ready_ff ? 16'h8000 : 16'h0000;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      addr_in      = addr_ff;
      dat_in       = dat_ff;
      ir_in        = ir_ff;
      pc_in        = pc_ff;
      start_pc_in  = start_pc_ff;
      flags_in     = flags_ff;
      stopped_in   = stopped_ff;
      taken_in     = taken_ff;
      key_ready_in = key_ready_ff;
      key_char_in  = key_char_ff;
      status_in    = status_ff;
      ochar_in     = ochar_ff;
      saddr_in     = saddr_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we = 1'b0;
      mem_wa = addr_ff[AW-1:0];
      mem_wd = 16'd0;
      reg_we = 1'b0;
      r7_we  = 1'b0;
      reg_wa = dr;
      reg_wd = dat_ff;

      unique case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEMORY_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               status_in    = ST_OK;
               ochar_in     = 8'd0;
               saddr_in     = 16'd0;
               taken_in     = 1'b0;
               key_ready_in = req_data.key_ready;
               key_char_in  = req_data.key_char;
               if (req_data.kind == KIND_LOAD) begin
                  mem_we   = 1'b1;
                  mem_wa   = req_data.load_address[AW-1:0];
                  mem_wd   = req_data.load_data;
                  state_in = S_FIN;
               end else if (stopped_ff) begin
                  status_in = ST_HALTED;
                  state_in  = S_FIN;
               end else begin
                  addr_in  = pc_ff;
                  phase_in = PH_FETCH;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            // keyboard status read refreshes the status register, and the data register when a key is ready
            if (addr_ff == KB_STATUS_ADDR) begin
               mem_we   = 1'b1;
               mem_wa   = KB_STATUS_ADDR[AW-1:0];
               mem_wd   = kb_val;
               dat_in   = kb_val;
               taken_in = taken_ff | key_ready_ff;
               state_in = key_ready_ff ? S_KBD : S_PH;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_KBD: begin
            mem_we   = 1'b1;
            mem_wa   = KB_DATA_ADDR[AW-1:0];
            mem_wd   = {8'd0, key_char_ff};
            state_in = S_PH;
         end
         S_WAIT: begin
            dat_in   = mem_q;
            state_in = S_PH;
         end
         S_PH: begin
            unique case (phase_ff)
               PH_FETCH: begin
                  ir_in    = dat_ff;
                  pc_in    = pc_ff + 16'd1;
                  state_in = S_EXEC;
               end
               PH_IND: begin
                  // STI stores through the pointer without reading the target word
                  addr_in = dat_ff;
                  if (opc == OP_LDI) begin
                     phase_in = PH_LOAD;
                     state_in = S_RD;
                  end else begin
                     phase_in = PH_STORE;
                     state_in = S_PH;
                  end
               end
               PH_LOAD: begin
                  reg_we   = 1'b1;
                  flags_in = flags_of(dat_ff);
                  state_in = S_FIN;
               end
               PH_STORE: begin
                  mem_we   = 1'b1;
                  mem_wa   = addr_ff[AW-1:0];
                  mem_wd   = regs_ff[dr];
                  state_in = S_FIN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_EXEC: begin
            state_in = S_FIN;
            unique case (opc)
               OP_ADD, OP_AND, OP_NOT: begin
                  reg_we = 1'b1;
                  if (opc == OP_ADD) reg_wd = regs_ff[sr1] + opb;
                  else if (opc == OP_AND) reg_wd = regs_ff[sr1] & opb;
                  else reg_wd = ~regs_ff[sr1];
                  flags_in = flags_of(reg_wd);
               end
               OP_BR: if ((dr & flags_ff) != 3'd0) pc_in = pc_ff + off9;
               OP_JMP: pc_in = regs_ff[sr1];
               OP_JSR: begin
                  r7_we = 1'b1;
                  pc_in = ir_ff[11] ? pc_ff + off11 : regs_ff[sr1];
               end
               OP_LD, OP_LDI, OP_ST, OP_STI: begin
                  addr_in  = pc_ff + off9;
                  state_in = S_RD;
                  if (opc == OP_LD) phase_in = PH_LOAD;
                  else if (opc == OP_ST) begin
                     mem_we   = 1'b1;
                     mem_wa   = addr_in[AW-1:0];
                     mem_wd   = regs_ff[dr];
                     state_in = S_FIN;
                  end else phase_in = PH_IND;
               end
               OP_LDR: begin
                  addr_in  = regs_ff[sr1] + off6;
                  phase_in = PH_LOAD;
                  state_in = S_RD;
               end
               OP_STR: begin
                  mem_we = 1'b1;
                  mem_wa = addr_in[AW-1:0];
                  addr_in = regs_ff[sr1] + off6;
                  mem_wa = addr_in[AW-1:0];
                  mem_wd = regs_ff[dr];
               end
               OP_LEA: begin
                  reg_we   = 1'b1;
                  reg_wd   = pc_ff + off9;
                  flags_in = flags_of(reg_wd);
               end
               OP_TRAP: begin
                  if ((vec == TV_GETC || vec == TV_IN) && !key_ready_ff) begin
                     status_in = ST_NEEDKEY;
                     pc_in     = pc_ff - 16'd1;
                  end else begin
                     r7_we = 1'b1;
                     unique case (vec)
                        TV_GETC, TV_IN: begin
                           reg_we   = 1'b1;
                           reg_wa   = 3'd0;
                           reg_wd   = {8'd0, key_char_ff};
                           flags_in = flags_of(reg_wd);
                           taken_in = 1'b1;
                           if (vec == TV_IN) begin
                              status_in = ST_CHAR;
                              ochar_in  = key_char_ff;
                           end
                        end
                        TV_OUT: begin
                           status_in = ST_CHAR;
                           ochar_in  = regs_ff[0][7:0];
                        end
                        TV_PUTS: begin
                           status_in = ST_STRING;
                           saddr_in  = regs_ff[0];
                        end
                        TV_PUTSP: begin
                           status_in = ST_PSTRING;
                           saddr_in  = regs_ff[0];
                        end
                        TV_HALT: begin
                           status_in  = ST_HALTED;
                           stopped_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
               default: begin
                  // RTI and reserved opcode
                  status_in  = ST_ILLEGAL;
                  stopped_in = 1'b1;
               end
            endcase
         end
         S_FIN: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.next_pc        = pc_ff;
               rsp_in.out_char       = ochar_ff;
               rsp_in.string_address = saddr_ff;
               rsp_in.key_taken      = taken_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid && csr_ready) begin
         start_pc_in = csr_data;
         pc_in       = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
      end else begin
         if (r7_we) regs_ff[7] <= pc_ff;
         if (reg_we) regs_ff[reg_wa] <= reg_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         start_pc_ff  <= START_PC_RESET;
         pc_ff        <= START_PC_RESET;
         flags_ff     <= FLAG_Z;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_pc_ff  <= start_pc_in;
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff     <= phase_in;
      addr_ff      <= addr_in;
      dat_ff       <= dat_in;
      ir_ff        <= ir_in;
      taken_ff     <= taken_in;
      key_ready_ff <= key_ready_in;
      key_char_ff  <= key_char_in;
      status_ff    <= status_in;
      ochar_ff     <= ochar_in;
      saddr_ff     <= saddr_in;
      rsp_ff       <= rsp_in;
   end

   a_clr_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> req_stall)
      else $error("clearing pass let a word in");

   a_kbd_taken: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_KBD |-> taken_ff && key_ready_ff)
      else $error("keyboard data write without a key");

   a_stop_src: assert property (@(posedge clock) disable iff (reset)
      $rose(stopped_ff) |-> $past(state_ff) == S_EXEC)
      else $error("stopped set outside execute");

   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished word not moved to rsp register");
endmodule
`default_nettype wire
